>>> design/sor_pkg.sv
// Shared types and constants for the SOR linear solver.
`timescale 1ns / 1ps
`default_nettype none

package sor_pkg;

    localparam int MAX_N_DEF = 16;
    localparam int CFG_DW    = 31;

    typedef enum logic [1:0] {
        OP_LOAD_A = 2'd0,
        OP_LOAD_B = 2'd1,
        OP_LOAD_X = 2'd2,
        OP_SOLVE  = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_ZDIAG = 2'd1,
        ST_SAT   = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        CFG_SIZE     = 3'd0,
        CFG_MAX_SWP  = 3'd1,
        CFG_RELAX    = 3'd2,
        CFG_NORM_TOL = 3'd3,
        CFG_STEP_TOL = 3'd4
    } t_cfg_idx;

    localparam logic [4:0]  SIZE_RST  = 5'd16;
    localparam logic [15:0] MAXSW_RST = 16'd100;
    localparam logic [17:0] RELAX_RST = 18'd98304;

    typedef struct packed {
        t_opcode            opcode;
        logic [3:0]         row;
        logic [3:0]         col;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic [3:0]         index;
        logic signed [31:0] solution;
        logic               last;
        logic               converged;
        logic [15:0]        sweeps_done;
        t_status            status;
    } t_out_item;

endpackage

`default_nettype wire

>>> design/sor_linear_solver.sv
// Top level of the Q16.16 successive over-relaxation linear solver.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//  - Input channel (i_in_valid / o_in_stall / i_in_data) carries load and solve
//    transactions. Loads of A, b and x0 are accepted back to back while the
//    block is idle, so a memory can stream them.
//  - A solve transaction raises o_in_stall until the last result is loaded
//    into the output register. A sweep is paced by the shared 33x33
//    multiplier, the 64-step radix-2 divider per row and the single read
//    port of the matrix memory. Each convergence test after the first sweep
//    runs two 32-step square roots. A zero-diagonal check precedes the sweeps.
//  - Output channel (o_out_valid / i_out_stall / o_out_data) gives n results,
//    one per component; a stall simply holds the output register and the
//    sequencer waits.
//  - Config port: i_cfg_we / i_cfg_addr / i_cfg_data, write only, while idle.
//  - Reset (synchronous, active low) clears control, config to defaults and
//    the output valid. Matrix, b, x and previous-x memories are not cleared.
module sor_linear_solver
    import sor_pkg::*;
#(
    parameter int MAX_N = MAX_N_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_data,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_addr,
    input  logic [CFG_DW-1:0] i_cfg_data
);

    localparam int IW = $clog2(MAX_N);
    localparam int AW = 2 * IW;
    localparam int NW = $clog2(MAX_N + 1);

    typedef enum logic [22:0] {
        S_IDLE    = 23'h000001,
        S_DG_RD   = 23'h000002,
        S_DG_CHK  = 23'h000004,
        S_SW_TOP  = 23'h000008,
        S_ROW_RD  = 23'h000010,
        S_ROW_LD  = 23'h000020,
        S_MAC_RD  = 23'h000040,
        S_MAC_MUL = 23'h000080,
        S_MAC_ACC = 23'h000100,
        S_DV_RUN  = 23'h000200,
        S_DV_END  = 23'h000400,
        S_REL_MIX = 23'h000800,
        S_REL_OUT = 23'h001000,
        S_SW_END  = 23'h002000,
        S_NM_RD   = 23'h004000,
        S_NM_SQX  = 23'h008000,
        S_NM_SQP  = 23'h010000,
        S_NM_ACC  = 23'h020000,
        S_SQ_RUN  = 23'h040000,
        S_SQ_END  = 23'h080000,
        S_CONV    = 23'h100000,
        S_EM_RD   = 23'h200000,
        S_EM_WR   = 23'h400000
    } t_state;

    t_state r_state;

    // configuration
    logic [4:0]  r_size;
    logic [15:0] r_max;
    logic [17:0] r_relax;
    logic [30:0] r_ntol;
    logic [30:0] r_stol;

    // memories and registered read data
    logic signed [31:0] r_mem_a [2**AW];
    logic signed [31:0] r_mem_b [2**IW];
    logic signed [31:0] r_mem_x [2**IW];
    logic signed [31:0] r_mem_p [2**IW];
    logic signed [31:0] r_rd_a, r_rd_b, r_rd_x, r_rd_p;

    logic [AW-1:0] w_ra_a, w_wa_a;
    logic [IW-1:0] w_ra_x, w_ra_p, w_ra_b, w_wa_x, w_wa_b;
    logic          w_re_a, w_re_x, w_re_p, w_re_b;
    logic          w_we_a, w_we_b, w_we_x, w_we_p;
    logic signed [31:0] w_wd_x;

    // sequencer state
    logic [NW-1:0] r_n, r_i, r_j, r_k;
    logic [15:0]   r_sweeps;
    logic          r_sat, r_zd, r_conv;

    // datapath
    logic signed [63:0] r_acc, r_prod;
    logic signed [31:0] r_d, r_xi, r_q;
    logic [63:0]        r_dq;
    logic [31:0]        r_rem, r_dvs;
    logic               r_qneg;
    logic [5:0]         r_cnt;
    logic [63:0]        r_suma, r_sumb, r_sq_v;
    logic [35:0]        r_sq_rem;
    logic [31:0]        r_sq_root, r_na, r_nb, r_er2;
    logic               r_sq_sel;

    logic      r_out_valid;
    t_out_item r_out;

    // ------------------------------------------------------------------
    // combinational helpers
    // ------------------------------------------------------------------
    logic          w_in_acc, w_row_ok, w_col_ok;
    logic [NW-1:0] w_n_clamp, w_i_nx, w_j_nx, w_k_nx;
    logic [IW-1:0] w_ld_row, w_ld_col;

    assign w_in_acc = i_in_valid && (r_state == S_IDLE);
    assign w_row_ok = 32'(i_in_data.row) < MAX_N;
    assign w_col_ok = 32'(i_in_data.col) < MAX_N;
    assign w_ld_row = IW'(i_in_data.row);
    assign w_ld_col = IW'(i_in_data.col);
    assign w_i_nx   = r_i + NW'(1);
    assign w_j_nx   = r_j + NW'(1);
    assign w_k_nx   = r_k + NW'(1);

    always_comb begin
        if (r_size == 5'd0) begin
            w_n_clamp = NW'(1);
        end else if (32'(r_size) > MAX_N) begin
            w_n_clamp = NW'(MAX_N);
        end else begin
            w_n_clamp = NW'(r_size);
        end
    end

    // shared multiplier; product registered in r_prod
    logic signed [32:0] w_ma, w_mb, w_omw;
    logic signed [65:0] w_mp;

    assign w_omw = 33'sd65536 - $signed({15'd0, r_relax});

    always_comb begin
        unique case (r_state)
            S_MAC_MUL: begin
                w_ma = {r_rd_a[31], r_rd_a};
                w_mb = {r_rd_x[31], r_rd_x};
            end
            S_DV_END: begin
                w_ma = w_omw;
                w_mb = {r_xi[31], r_xi};
            end
            S_REL_MIX: begin
                w_ma = $signed({15'd0, r_relax});
                w_mb = {r_q[31], r_q};
            end
            S_NM_SQX: begin
                w_ma = {r_rd_x[31], r_rd_x};
                w_mb = {r_rd_x[31], r_rd_x};
            end
            S_NM_SQP: begin
                w_ma = {r_rd_p[31], r_rd_p};
                w_mb = {r_rd_p[31], r_rd_p};
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end
    assign w_mp = w_ma * w_mb;

    // row sum: acc - a_ij*x_j, saturating
    logic signed [63:0] w_neg;
    logic [64:0]        w_s65;
    logic               w_s_ovf;
    assign w_neg   = -r_prod;
    assign w_s65   = {r_acc[63], r_acc} + {w_neg[63], w_neg};
    assign w_s_ovf = w_s65[64] ^ w_s65[63];

    // divider step: restoring, one quotient bit per cycle
    logic [32:0] w_dv_sh, w_dv_df;
    logic        w_dv_ge;
    assign w_dv_sh = {r_rem, r_dq[63]};
    assign w_dv_df = w_dv_sh - {1'b0, r_dvs};
    assign w_dv_ge = !w_dv_df[32];

    // divider start values
    logic [63:0] w_acc_mag;
    logic [31:0] w_d_mag;
    assign w_acc_mag = r_acc[63] ? 64'(-r_acc) : 64'(r_acc);
    assign w_d_mag   = r_d[31] ? 32'(-r_d) : 32'(r_d);

    // relaxed value: round to nearest, back to Q16.16, clamp
    logic signed [63:0] w_t, w_ts;
    assign w_t  = r_acc + r_prod + 64'sd32768;
    assign w_ts = w_t >>> 16;
    always_comb begin
        if (w_ts > 64'sd2147483647) begin
            w_wd_x = 32'sh7FFFFFFF;
        end else if (w_ts < -64'sd2147483648) begin
            w_wd_x = 32'sh80000000;
        end else begin
            w_wd_x = w_ts[31:0];
        end
    end

    // unsigned sum of squares
    logic [64:0] w_sq_sum;
    assign w_sq_sum = (r_state == S_NM_SQP) ? {1'b0, r_suma} + {1'b0, r_prod}
                                            : {1'b0, r_sumb} + {1'b0, r_prod};

    // component change
    logic [32:0] w_df, w_df_abs;
    assign w_df     = {r_rd_x[31], r_rd_x} - {r_rd_p[31], r_rd_p};
    assign w_df_abs = w_df[32] ? -w_df : w_df;

    // square root step: two bits of radicand per cycle
    logic [35:0] w_sq_sh, w_sq_tr, w_sq_df;
    logic        w_sq_ge;
    assign w_sq_sh = {r_sq_rem[33:0], r_sq_v[63:62]};
    assign w_sq_tr = {2'b00, r_sq_root, 2'b01};
    assign w_sq_df = w_sq_sh - w_sq_tr;
    assign w_sq_ge = w_sq_sh >= w_sq_tr;

    logic [31:0] w_er1;
    assign w_er1 = (r_na > r_nb) ? r_na - r_nb : r_nb - r_na;

    logic w_zd_now;
    assign w_zd_now = r_zd || (r_rd_a == 32'sd0);

    // ------------------------------------------------------------------
    // memory ports
    // ------------------------------------------------------------------
    always_comb begin
        w_re_a = 1'b0;
        w_re_b = 1'b0;
        w_re_x = 1'b0;
        w_re_p = 1'b0;
        w_ra_a = {r_i[IW-1:0], r_i[IW-1:0]};
        w_ra_b = r_i[IW-1:0];
        w_ra_x = r_i[IW-1:0];
        w_ra_p = r_k[IW-1:0];
        unique case (r_state)
            S_DG_RD: begin
                w_re_a = 1'b1;
                w_ra_a = {r_k[IW-1:0], r_k[IW-1:0]};
            end
            S_ROW_RD: begin
                w_re_a = 1'b1;
                w_re_b = 1'b1;
                w_re_x = 1'b1;
            end
            S_MAC_RD: begin
                w_re_a = (r_j != r_n) && (r_j != r_i);
                w_re_x = w_re_a;
                w_ra_a = {r_i[IW-1:0], r_j[IW-1:0]};
                w_ra_x = r_j[IW-1:0];
            end
            S_NM_RD: begin
                w_re_x = (r_k != r_n);
                w_re_p = w_re_x;
                w_ra_x = r_k[IW-1:0];
            end
            S_EM_RD: begin
                w_re_x = (r_k != r_n);
                w_ra_x = r_k[IW-1:0];
            end
            default: begin
            end
        endcase
    end

    assign w_wa_a = {w_ld_row, w_ld_col};
    assign w_wa_b = w_ld_row;
    assign w_we_a = w_in_acc && (i_in_data.opcode == OP_LOAD_A) && w_row_ok && w_col_ok;
    assign w_we_b = w_in_acc && (i_in_data.opcode == OP_LOAD_B) && w_row_ok;
    assign w_we_p = (r_state == S_REL_OUT);
    assign w_we_x = w_we_p || (w_in_acc && (i_in_data.opcode == OP_LOAD_X) && w_row_ok);
    assign w_wa_x = w_we_p ? r_i[IW-1:0] : w_ld_row;

    always_ff @(posedge i_clk) begin
        if (w_we_a) begin
            r_mem_a[w_wa_a] <= i_in_data.value;
        end
        if (w_re_a) begin
            r_rd_a <= r_mem_a[w_ra_a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we_b) begin
            r_mem_b[w_wa_b] <= i_in_data.value;
        end
        if (w_re_b) begin
            r_rd_b <= r_mem_b[w_ra_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we_x) begin
            r_mem_x[w_wa_x] <= w_we_p ? w_wd_x : i_in_data.value;
        end
        if (w_re_x) begin
            r_rd_x <= r_mem_x[w_ra_x];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we_p) begin
            r_mem_p[r_i[IW-1:0]] <= r_xi;
        end
        if (w_re_p) begin
            r_rd_p <= r_mem_p[w_ra_p];
        end
    end

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size  <= SIZE_RST;
            r_max   <= MAXSW_RST;
            r_relax <= RELAX_RST;
            r_ntol  <= '0;
            r_stol  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_SIZE:     r_size  <= i_cfg_data[4:0];
                CFG_MAX_SWP:  r_max   <= i_cfg_data[15:0];
                CFG_RELAX:    r_relax <= i_cfg_data[17:0];
                CFG_NORM_TOL: r_ntol  <= i_cfg_data[30:0];
                CFG_STEP_TOL: r_stol  <= i_cfg_data[30:0];
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // payload registers (no reset)
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_ROW_LD: begin
                r_acc <= {{16{r_rd_b[31]}}, r_rd_b, 16'h0000};
                r_d   <= r_rd_a;
                r_xi  <= r_rd_x;
            end
            S_MAC_RD: begin
                r_dq   <= w_acc_mag;
                r_rem  <= '0;
                r_dvs  <= w_d_mag;
                r_qneg <= r_acc[63] ^ r_d[31];
            end
            S_MAC_MUL: r_prod <= w_mp[63:0];
            S_MAC_ACC: begin
                if (w_s_ovf) begin
                    r_acc <= w_s65[64] ? 64'sh8000000000000000 : 64'sh7FFFFFFFFFFFFFFF;
                end else begin
                    r_acc <= w_s65[63:0];
                end
            end
            S_DV_RUN: begin
                r_rem <= w_dv_ge ? w_dv_df[31:0] : w_dv_sh[31:0];
                r_dq  <= {r_dq[62:0], w_dv_ge};
            end
            S_DV_END: begin
                r_prod <= w_mp[63:0];
                if (!r_qneg) begin
                    r_q <= (r_dq > 64'h7FFFFFFF) ? 32'sh7FFFFFFF : r_dq[31:0];
                end else begin
                    r_q <= (r_dq > 64'h80000000) ? 32'sh80000000 : -r_dq[31:0];
                end
            end
            S_REL_MIX: begin
                r_acc  <= r_prod;
                r_prod <= w_mp[63:0];
            end
            S_SW_END: begin
                r_suma <= '0;
                r_sumb <= '0;
                r_er2  <= '0;
            end
            S_NM_RD: begin
                r_sq_v    <= r_suma;
                r_sq_rem  <= '0;
                r_sq_root <= '0;
            end
            S_NM_SQX: begin
                r_prod <= w_mp[63:0];
                if (w_df_abs[31:0] > r_er2) begin
                    r_er2 <= w_df_abs[31:0];
                end
            end
            S_NM_SQP: begin
                r_suma <= w_sq_sum[64] ? '1 : w_sq_sum[63:0];
                r_prod <= w_mp[63:0];
            end
            S_NM_ACC: r_sumb <= w_sq_sum[64] ? '1 : w_sq_sum[63:0];
            S_SQ_RUN: begin
                r_sq_rem  <= w_sq_ge ? w_sq_df : w_sq_sh;
                r_sq_root <= {r_sq_root[30:0], w_sq_ge};
                r_sq_v    <= {r_sq_v[61:0], 2'b00};
            end
            S_SQ_END: begin
                if (!r_sq_sel) begin
                    r_na      <= r_sq_root;
                    r_sq_v    <= r_sumb;
                    r_sq_rem  <= '0;
                    r_sq_root <= '0;
                end else begin
                    r_nb <= r_sq_root;
                end
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_n         <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_k         <= '0;
            r_cnt       <= '0;
            r_sweeps    <= '0;
            r_sat       <= 1'b0;
            r_zd        <= 1'b0;
            r_conv      <= 1'b0;
            r_sq_sel    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc && (i_in_data.opcode == OP_SOLVE)) begin
                        r_n      <= w_n_clamp;
                        r_sat    <= 1'b0;
                        r_zd     <= 1'b0;
                        r_conv   <= 1'b0;
                        r_sweeps <= '0;
                        r_k      <= '0;
                        r_state  <= S_DG_RD;
                    end
                end
                S_DG_RD: r_state <= S_DG_CHK;
                S_DG_CHK: begin
                    r_zd <= w_zd_now;
                    r_k  <= w_k_nx;
                    if (w_k_nx == r_n) begin
                        r_k     <= '0;
                        r_state <= w_zd_now ? S_EM_RD : S_SW_TOP;
                    end else begin
                        r_state <= S_DG_RD;
                    end
                end
                S_SW_TOP: begin
                    r_i <= '0;
                    r_k <= '0;
                    r_state <= (r_sweeps >= r_max) ? S_EM_RD : S_ROW_RD;
                end
                S_ROW_RD: r_state <= S_ROW_LD;
                S_ROW_LD: begin
                    r_j     <= '0;
                    r_state <= S_MAC_RD;
                end
                S_MAC_RD: begin
                    if (r_j == r_n) begin
                        r_cnt   <= '0;
                        r_state <= S_DV_RUN;
                    end else if (r_j == r_i) begin
                        r_j <= w_j_nx;
                    end else begin
                        r_state <= S_MAC_MUL;
                    end
                end
                S_MAC_MUL: r_state <= S_MAC_ACC;
                S_MAC_ACC: begin
                    if (w_s_ovf) begin
                        r_sat <= 1'b1;
                    end
                    r_j     <= w_j_nx;
                    r_state <= S_MAC_RD;
                end
                S_DV_RUN: begin
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd63) begin
                        r_state <= S_DV_END;
                    end
                end
                S_DV_END: begin
                    if ((!r_qneg && (r_dq > 64'h7FFFFFFF)) ||
                        (r_qneg && (r_dq > 64'h80000000))) begin
                        r_sat <= 1'b1;
                    end
                    r_state <= S_REL_MIX;
                end
                S_REL_MIX: r_state <= S_REL_OUT;
                S_REL_OUT: begin
                    if ((w_ts > 64'sd2147483647) || (w_ts < -64'sd2147483648)) begin
                        r_sat <= 1'b1;
                    end
                    r_i     <= w_i_nx;
                    r_state <= (w_i_nx == r_n) ? S_SW_END : S_ROW_RD;
                end
                S_SW_END: begin
                    r_sweeps <= r_sweeps + 16'd1;
                    r_k      <= '0;
                    // no convergence test after the first sweep
                    r_state  <= (r_sweeps != 16'd0) ? S_NM_RD : S_SW_TOP;
                end
                S_NM_RD: begin
                    if (r_k == r_n) begin
                        r_cnt    <= '0;
                        r_sq_sel <= 1'b0;
                        r_state  <= S_SQ_RUN;
                    end else begin
                        r_state <= S_NM_SQX;
                    end
                end
                S_NM_SQX: r_state <= S_NM_SQP;
                S_NM_SQP: begin
                    if (w_sq_sum[64]) begin
                        r_sat <= 1'b1;
                    end
                    r_state <= S_NM_ACC;
                end
                S_NM_ACC: begin
                    if (w_sq_sum[64]) begin
                        r_sat <= 1'b1;
                    end
                    r_k     <= w_k_nx;
                    r_state <= S_NM_RD;
                end
                S_SQ_RUN: begin
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd31) begin
                        r_state <= S_SQ_END;
                    end
                end
                S_SQ_END: begin
                    r_cnt <= '0;
                    if (!r_sq_sel) begin
                        r_sq_sel <= 1'b1;
                        r_state  <= S_SQ_RUN;
                    end else begin
                        r_state <= S_CONV;
                    end
                end
                S_CONV: begin
                    r_k <= '0;
                    if ((w_er1 <= {1'b0, r_ntol}) || (r_er2 <= {1'b0, r_stol})) begin
                        r_conv  <= 1'b1;
                        r_state <= S_EM_RD;
                    end else begin
                        r_state <= S_SW_TOP;
                    end
                end
                S_EM_RD: r_state <= (r_k == r_n) ? S_IDLE : S_EM_WR;
                S_EM_WR: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_k         <= w_k_nx;
                        r_state     <= S_EM_RD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if ((r_state == S_EM_WR) && (!r_out_valid || !i_out_stall)) begin
            r_out.index       <= 4'(r_k);
            r_out.solution    <= r_rd_x;
            r_out.last        <= (w_k_nx == r_n);
            r_out.converged   <= r_conv;
            r_out.sweeps_done <= r_sweeps;
            r_out.status      <= r_zd ? ST_ZDIAG : (r_sat ? ST_SAT : ST_OK);
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

>>> design/sor_checker.sv
// Port-level assertions for the SOR linear solver, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module sor_checker
    import sor_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_item  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_data
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // a solve transaction blocks the input
    a_solve_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in_data.opcode == OP_SOLVE) |=> o_in_stall)
        else $error("input open right after solve");

    // the block stays busy while the components before the last are taken
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_out_data.last |=> o_in_stall)
        else $error("input open in the middle of a result run");

    // a zero diagonal means no sweep was made
    a_zdiag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == ST_ZDIAG)
        |-> (o_out_data.sweeps_done == 16'd0) && !o_out_data.converged)
        else $error("zero diagonal with sweeps");

endmodule

bind sor_linear_solver sor_checker u_sor_checker (.*);

`default_nettype wire
